[design/spjd_pkg.sv]
// Package for the strict-priority job dispatcher.
// Holds queue sizing constants, operation codes, the controller state type
// and the controller-to-datapath command struct. No dependencies.
package spjd_pkg;

  localparam int QUEUE_DEPTH = 16;  // must be a power of two
  localparam int HANDLE_BITS = 32;
  localparam int NUM_QUEUES  = 4;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QSEL_W = $clog2(NUM_QUEUES);
  localparam int ADDR_W = QSEL_W + PTR_W;
  localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

  typedef enum logic [1:0] {
    FUNC_PUSH_WORKER = 2'd0,
    FUNC_PUSH_MAIN   = 2'd1,
    FUNC_POP_WORKER  = 2'd2,
    FUNC_POP_MAIN    = 2'd3
  } func_e;

  localparam logic [QSEL_W-1:0] Q_HIGH   = QSEL_W'(0);
  localparam logic [QSEL_W-1:0] Q_NORMAL = QSEL_W'(1);
  localparam logic [QSEL_W-1:0] Q_LOW    = QSEL_W'(2);
  localparam logic [QSEL_W-1:0] Q_MAIN   = QSEL_W'(3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic load;  // capture the incoming word
    logic exec;  // perform the queue access
  } dp_cmd_t;

endpackage

[design/spjd_ram.sv]
// Generic single-port RAM with registered read data.
// Used for the shared job queue storage; no dependencies.
module spjd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/spjd_ctrl.sv]
// Controller for the job dispatcher: sequences accept, queue access and result.
// Depends on spjd_pkg.
module spjd_ctrl import spjd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  output logic    done_o,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    done_o     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_EXEC: cmd_o.exec = 1'b1;
      ST_RESP: done_o = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

[design/spjd_dp.sv]
// Datapath for the job dispatcher: queue pointers, occupancy counts, priority
// select and the shared queue RAM. Depends on spjd_pkg and spjd_ram.
module spjd_dp import spjd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  input  logic [1:0]             func_i,
  input  logic [1:0]             priority_req_i,
  input  logic [HANDLE_BITS-1:0] job_handle_i,
  output logic [HANDLE_BITS-1:0] out_job_o,
  output logic                   found_o,
  output logic                   overflow_o
);

  logic [1:0]             func_q;
  logic [1:0]             prio_q;
  logic [HANDLE_BITS-1:0] handle_q;

  logic [PTR_W-1:0] rd_ptr_q [NUM_QUEUES];
  logic [PTR_W-1:0] rd_ptr_d [NUM_QUEUES];
  logic [CNT_W-1:0] occ_q    [NUM_QUEUES];
  logic [CNT_W-1:0] occ_d    [NUM_QUEUES];
  logic found_q, found_d;
  logic overflow_q, overflow_d;

  logic [QSEL_W-1:0]      qsel;
  logic                   is_push;
  logic                   is_pop;
  logic                   full;
  logic                   empty;
  logic                   ram_we;
  logic                   ram_re;
  logic [PTR_W-1:0]       idx;
  logic [ADDR_W-1:0]      ram_addr;
  logic [HANDLE_BITS-1:0] ram_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_i;
      prio_q   <= priority_req_i;
      handle_q <= job_handle_i;
    end
  end

  // Queue select. A worker pop takes the first non-empty queue in priority order.
  always_comb begin
    qsel    = Q_MAIN;
    is_push = 1'b0;
    is_pop  = 1'b0;
    case (func_q)
      FUNC_PUSH_WORKER: begin
        qsel    = prio_q[QSEL_W-1:0];
        is_push = (prio_q <= 2'(Q_LOW));
      end
      FUNC_PUSH_MAIN: begin
        qsel    = Q_MAIN;
        is_push = 1'b1;
      end
      FUNC_POP_WORKER: begin
        is_pop = 1'b1;
        if (occ_q[Q_HIGH] != '0) begin
          qsel = Q_HIGH;
        end else if (occ_q[Q_NORMAL] != '0) begin
          qsel = Q_NORMAL;
        end else begin
          qsel = Q_LOW;
        end
      end
      default: begin
        qsel   = Q_MAIN;
        is_pop = 1'b1;
      end
    endcase
  end

  assign full  = (occ_q[qsel] == CNT_W'(QUEUE_DEPTH));
  assign empty = (occ_q[qsel] == '0);

  // The tail wraps naturally because the depth is a power of two.
  assign idx      = is_push ? PTR_W'(rd_ptr_q[qsel] + occ_q[qsel][PTR_W-1:0])
                            : rd_ptr_q[qsel];
  assign ram_addr = {qsel, idx};
  assign ram_we   = cmd_i.exec && is_push && !full;
  assign ram_re   = cmd_i.exec && is_pop && !empty;

  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    occ_d      = occ_q;
    found_d    = found_q;
    overflow_d = overflow_q;
    if (cmd_i.exec) begin
      found_d    = ram_re;
      overflow_d = is_push && full;
      if (ram_we) begin
        occ_d[qsel] = CNT_W'(occ_q[qsel] + 1'b1);
      end
      if (ram_re) begin
        occ_d[qsel]    = CNT_W'(occ_q[qsel] - 1'b1);
        rd_ptr_d[qsel] = PTR_W'(rd_ptr_q[qsel] + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rd_ptr_q[i] <= '0;
        occ_q[i]    <= '0;
      end
      found_q    <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      rd_ptr_q   <= rd_ptr_d;
      occ_q      <= occ_d;
      found_q    <= found_d;
      overflow_q <= overflow_d;
    end
  end

  spjd_ram #(
    .WIDTH(HANDLE_BITS),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (handle_q),
    .rdata_o (ram_rdata)
  );

  assign out_job_o  = found_q ? ram_rdata : '0;
  assign found_o    = found_q;
  assign overflow_o = overflow_q;

endmodule

[design/strict_priority_job_dispatcher_top.sv]
// Top level of the strict-priority job dispatcher.
// Depends on spjd_pkg, spjd_ctrl and spjd_dp.

// Four job queues (high, normal, low, main-thread) of QUEUE_DEPTH handles each
// share one single-port RAM. Each operation runs in order: the word is
// taken when start is high and busy is low, the next cycle makes the one RAM
// access (write at the tail or read at the head), and the cycle after that
// shows the result with done_o high for exactly one cycle; busy stays high
// through both, so no new word is taken before the result is shown. The
// receiver cannot stall: a result must be captured in the cycle done_o is
// high. A push into a full queue is dropped and reported by overflow_o; a
// pop from empty queues returns found_o low and out_job_o zero.
module strict_priority_job_dispatcher_top import spjd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             func_i,
  input  logic [1:0]             priority_req_i,
  input  logic [HANDLE_BITS-1:0] job_handle_i,
  output logic                   done_o,
  output logic [HANDLE_BITS-1:0] out_job_o,
  output logic                   found_o,
  output logic                   overflow_o
);

  dp_cmd_t cmd;

  spjd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  spjd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (func_i),
    .priority_req_i (priority_req_i),
    .job_handle_i   (job_handle_i),
    .out_job_o      (out_job_o),
    .found_o        (found_o),
    .overflow_o     (overflow_o)
  );

endmodule
